/* design/assert_macros.svh */
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CHK_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/trbb_pkg.sv */
// Types, constants and saturation helpers for the transformed rectangle box unit
package trbb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int N_CORNERS = 4;
    localparam int N_COMP    = 3;
    localparam int DIV_STEPS = 32;
    // pre-stages (abs, range check) + steps + final clamp
    localparam int DIV_LAT   = DIV_STEPS + 3;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        CFG_RECT_MIN_X = 2'd0,
        CFG_RECT_MAX_X = 2'd1,
        CFG_RECT_MIN_Z = 2'd2,
        CFG_RECT_MAX_Z = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] r0c0;
        logic signed [31:0] r0c1;
        logic signed [31:0] r0c2;
        logic signed [31:0] r0c3;
        logic signed [31:0] r2c0;
        logic signed [31:0] r2c1;
        logic signed [31:0] r2c2;
        logic signed [31:0] r2c3;
        logic signed [31:0] r3c0;
        logic signed [31:0] r3c1;
        logic signed [31:0] r3c2;
        logic signed [31:0] r3c3;
    } t_in;

    typedef struct packed {
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
        logic               degenerate;
    } t_out;

    // Control travelling beside the divider lanes
    typedef struct packed {
        logic valid;
        logic degen;
    } t_ctl;

    // Signed 64-bit add, saturating
    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                      input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) begin
            sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            sat_add64 = s[63:0];
        end
    endfunction

    // Signed 64 to 32 clamp
    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'(Q_MAX)) begin
            clamp32 = Q_MAX;
        end else if (v < 64'(Q_MIN)) begin
            clamp32 = Q_MIN;
        end else begin
            clamp32 = v[31:0];
        end
    endfunction

endpackage

/* design/trbb_xform.sv */
// Corner transform: products, two saturating adds, w scaling, four stages
module trbb_xform (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  trbb_pkg::t_in            i_data,
    input  logic signed [31:0]       i_min_x,
    input  logic signed [31:0]       i_max_x,
    input  logic signed [31:0]       i_min_z,
    input  logic signed [31:0]       i_max_z,
    output logic                     o_valid,
    output logic                     o_degen,
    output logic signed [63:0]       o_num [trbb_pkg::N_CORNERS][trbb_pkg::N_COMP],
    output logic signed [31:0]       o_den [trbb_pkg::N_CORNERS]
);

    logic signed [31:0] w_row0 [4];
    logic signed [31:0] w_row2 [4];
    logic signed [31:0] w_row3 [4];
    logic signed [31:0] w_cx   [trbb_pkg::N_CORNERS];
    logic signed [31:0] w_cz   [trbb_pkg::N_CORNERS];

    logic               r1_vld, r2_vld, r3_vld, r4_vld;
    logic signed [63:0] r1_px  [trbb_pkg::N_CORNERS][4];
    logic signed [63:0] r1_pz  [trbb_pkg::N_CORNERS][4];
    logic signed [63:0] r1_t   [4];
    logic signed [63:0] r2_sum [trbb_pkg::N_CORNERS][4];
    logic signed [63:0] r2_t   [4];
    logic signed [63:0] r3_acc [trbb_pkg::N_CORNERS][4];
    logic signed [63:0] r4_num [trbb_pkg::N_CORNERS][trbb_pkg::N_COMP];
    logic signed [31:0] r4_den [trbb_pkg::N_CORNERS];
    logic               r4_degen;

    logic signed [31:0] n_wq   [trbb_pkg::N_CORNERS];
    logic               n_degen;

    // matrix rows and corner coordinates
    always_comb begin
        w_row0[0] = i_data.r0c0; w_row0[1] = i_data.r0c1;
        w_row0[2] = i_data.r0c2; w_row0[3] = i_data.r0c3;
        w_row2[0] = i_data.r2c0; w_row2[1] = i_data.r2c1;
        w_row2[2] = i_data.r2c2; w_row2[3] = i_data.r2c3;
        w_row3[0] = i_data.r3c0; w_row3[1] = i_data.r3c1;
        w_row3[2] = i_data.r3c2; w_row3[3] = i_data.r3c3;
        w_cx[0] = i_min_x; w_cz[0] = i_max_z;
        w_cx[1] = i_min_x; w_cz[1] = i_min_z;
        w_cx[2] = i_max_x; w_cz[2] = i_min_z;
        w_cx[3] = i_max_x; w_cz[3] = i_max_z;
    end

    // w scaling and zero check
    always_comb begin
        n_degen = 1'b0;
        for (int k = 0; k < trbb_pkg::N_CORNERS; k++) begin
            n_wq[k] = trbb_pkg::clamp32(r3_acc[k][3] >>> trbb_pkg::FRAC_BITS);
            if (n_wq[k] == 32'sd0) begin
                n_degen = 1'b1;
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    // data stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 4; c++) begin
                r1_t[c] <= 64'(w_row3[c]) <<< trbb_pkg::FRAC_BITS;
                r2_t[c] <= r1_t[c];
                for (int k = 0; k < trbb_pkg::N_CORNERS; k++) begin
                    r1_px[k][c]  <= 64'(w_cx[k]) * 64'(w_row0[c]);
                    r1_pz[k][c]  <= 64'(w_cz[k]) * 64'(w_row2[c]);
                    r2_sum[k][c] <= trbb_pkg::sat_add64(r1_px[k][c], r1_pz[k][c]);
                    r3_acc[k][c] <= trbb_pkg::sat_add64(r2_sum[k][c], r2_t[c]);
                end
            end
            for (int k = 0; k < trbb_pkg::N_CORNERS; k++) begin
                r4_den[k] <= n_wq[k];
                for (int c = 0; c < trbb_pkg::N_COMP; c++) begin
                    r4_num[k][c] <= r3_acc[k][c];
                end
            end
            r4_degen <= n_degen;
        end
    end

    assign o_valid = r4_vld;
    assign o_degen = r4_degen;
    assign o_num   = r4_num;
    assign o_den   = r4_den;

endmodule

/* design/trbb_div.sv */
// Pipelined signed 64/32 divider lane, one quotient bit a stage, 32-bit clamp
module trbb_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [63:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_valid,
    output logic signed [31:0] o_quot
);

    localparam int NS = trbb_pkg::DIV_STEPS;

    // magnitude stage
    logic        r_p1_vld, r_p1_neg;
    logic [63:0] r_p1_a;
    logic [31:0] r_p1_d;
    // range check stage
    logic        r_p2_vld, r_p2_neg, r_p2_ovf;
    logic [63:0] r_p2_a;
    logic [31:0] r_p2_d;
    // step stages
    logic        r_st_vld [NS];
    logic        r_st_neg [NS];
    logic        r_st_ovf [NS];
    logic [63:0] r_st_a   [NS];
    logic [31:0] r_st_d   [NS];
    logic [63:0] n_st_a   [NS];
    // output stage
    logic               r_q_vld;
    logic signed [31:0] r_q;
    logic signed [31:0] n_q;
    logic [31:0]        w_uq;

    // one restoring step per stage
    always_comb begin
        logic [63:0] a_in;
        logic [31:0] d_in;
        logic [32:0] t;
        logic [32:0] r;
        logic        ge;
        for (int s = 0; s < NS; s++) begin
            a_in = (s == 0) ? r_p2_a : r_st_a[(s == 0) ? 0 : s - 1];
            d_in = (s == 0) ? r_p2_d : r_st_d[(s == 0) ? 0 : s - 1];
            t    = a_in[63:31];
            ge   = (t >= {1'b0, d_in});
            r    = ge ? (t - {1'b0, d_in}) : t;
            n_st_a[s] = {r[31:0], a_in[30:0], ge};
        end
    end

    // sign and clamp of the unsigned quotient
    assign w_uq = r_st_a[NS-1][31:0];
    always_comb begin
        if (!r_st_neg[NS-1]) begin
            if (r_st_ovf[NS-1] || w_uq > 32'h7FFF_FFFF) begin
                n_q = trbb_pkg::Q_MAX;
            end else begin
                n_q = w_uq;
            end
        end else begin
            if (r_st_ovf[NS-1] || w_uq > 32'h8000_0000) begin
                n_q = trbb_pkg::Q_MIN;
            end else begin
                n_q = 32'(32'd0 - w_uq);
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_q_vld  <= 1'b0;
            for (int s = 0; s < NS; s++) begin
                r_st_vld[s] <= 1'b0;
            end
        end else if (i_en) begin
            r_p1_vld <= i_valid;
            r_p2_vld <= r_p1_vld;
            r_st_vld[0] <= r_p2_vld;
            for (int s = 1; s < NS; s++) begin
                r_st_vld[s] <= r_st_vld[s-1];
            end
            r_q_vld <= r_st_vld[NS-1];
        end
    end

    // data stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1_a   <= i_num[63] ? 64'(64'd0 - i_num) : i_num;
            r_p1_d   <= i_den[31] ? 32'(32'd0 - i_den) : i_den;
            r_p1_neg <= i_num[63] ^ i_den[31];
            r_p2_a   <= r_p1_a;
            r_p2_d   <= r_p1_d;
            r_p2_neg <= r_p1_neg;
            r_p2_ovf <= (r_p1_a[63:32] >= r_p1_d);
            r_st_a[0]   <= n_st_a[0];
            r_st_d[0]   <= r_p2_d;
            r_st_neg[0] <= r_p2_neg;
            r_st_ovf[0] <= r_p2_ovf;
            for (int s = 1; s < NS; s++) begin
                r_st_a[s]   <= n_st_a[s];
                r_st_d[s]   <= r_st_d[s-1];
                r_st_neg[s] <= r_st_neg[s-1];
                r_st_ovf[s] <= r_st_ovf[s-1];
            end
            r_q <= n_q;
        end
    end

    assign o_valid = r_q_vld;
    assign o_quot  = r_q;

endmodule

/* design/trbb_minmax.sv */
// Two-stage min/max reduction over the corners, with zero-w override
module trbb_minmax (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  trbb_pkg::t_ctl     i_ctl,
    input  logic signed [31:0] i_q [trbb_pkg::N_CORNERS][trbb_pkg::N_COMP],
    output logic               o_valid,
    output trbb_pkg::t_out     o_data
);

    logic               r1_vld, r1_degen, r2_vld;
    logic signed [31:0] r1_lo [2][trbb_pkg::N_COMP];
    logic signed [31:0] r1_hi [2][trbb_pkg::N_COMP];
    trbb_pkg::t_out     r2_data;
    trbb_pkg::t_out     n2_data;
    logic signed [31:0] n_lo [trbb_pkg::N_COMP];
    logic signed [31:0] n_hi [trbb_pkg::N_COMP];

    // final pair and zero-w override
    always_comb begin
        for (int c = 0; c < trbb_pkg::N_COMP; c++) begin
            n_lo[c] = (r1_lo[1][c] < r1_lo[0][c]) ? r1_lo[1][c] : r1_lo[0][c];
            n_hi[c] = (r1_hi[1][c] > r1_hi[0][c]) ? r1_hi[1][c] : r1_hi[0][c];
        end
        if (r1_degen) begin
            n2_data = '0;
            n2_data.degenerate = 1'b1;
        end else begin
            n2_data.box_min_x  = n_lo[0];
            n2_data.box_min_y  = n_lo[1];
            n2_data.box_min_z  = n_lo[2];
            n2_data.box_max_x  = n_hi[0];
            n2_data.box_max_y  = n_hi[1];
            n2_data.box_max_z  = n_hi[2];
            n2_data.degenerate = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_ctl.valid;
            r2_vld <= r1_vld;
        end
    end

    // first pair stage: corners 0/1 and 2/3
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int p = 0; p < 2; p++) begin
                for (int c = 0; c < trbb_pkg::N_COMP; c++) begin
                    r1_lo[p][c] <= (i_q[2*p+1][c] < i_q[2*p][c]) ? i_q[2*p+1][c]
                                                                 : i_q[2*p][c];
                    r1_hi[p][c] <= (i_q[2*p+1][c] > i_q[2*p][c]) ? i_q[2*p+1][c]
                                                                 : i_q[2*p][c];
                end
            end
            r1_degen <= i_ctl.degen;
            r2_data  <= n2_data;
        end
    end

    assign o_valid = r2_vld;
    assign o_data  = r2_data;

endmodule

/* design/transformed_rect_bounding_box_unit.sv */
// Top level of the transformed rectangle bounding box unit
//
// Input channel: i_in_valid / o_in_stall carry one word holding rows 0, 2
// and 3 of a Q16.16 world matrix. Output channel: o_out_valid / i_out_stall
// carry one word with the box minimum and maximum in x, y, z and the
// degenerate flag (set, box all zero, when a corner's w rounds to zero).
// Config channel: i_cfg_valid / o_cfg_ready with a 2-bit register index and
// 32-bit data for the rectangle bounds; always ready. Write it only while
// the unit is empty.
// The pipeline runs through the corner transform, twelve divider lanes in
// parallel (one quotient bit a stage over 32 stages) and the min/max stages.
// One word is taken every cycle while the receiver does not stall.
// When the receiver stalls with a word on the output, the whole pipeline
// holds and o_in_stall rises in the same cycle; nothing is lost or repeated.
// Synchronous reset clears all valid bits and the bounds registers to zero.
module transformed_rect_bounding_box_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  trbb_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output trbb_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data
);

    localparam int NK = trbb_pkg::N_CORNERS;
    localparam int NC = trbb_pkg::N_COMP;

    logic               w_en;
    logic signed [31:0] r_min_x, r_max_x, r_min_z, r_max_z;
    logic               w_x_vld, w_x_degen;
    logic signed [63:0] w_num  [NK][NC];
    logic signed [31:0] w_den  [NK];
    logic signed [31:0] w_quot [NK][NC];
    logic               w_d_vld [NK][NC];
    logic               r_dg [trbb_pkg::DIV_LAT];
    trbb_pkg::t_ctl     w_ctl;

    // pipeline advances unless a finished word is held
    assign w_en        = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !w_en;
    assign o_cfg_ready = 1'b1;

    // bounds registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x <= '0;
            r_max_x <= '0;
            r_min_z <= '0;
            r_max_z <= '0;
        end else if (i_cfg_valid) begin
            case (trbb_pkg::t_cfg_idx'(i_cfg_index))
                trbb_pkg::CFG_RECT_MIN_X: r_min_x <= i_cfg_data;
                trbb_pkg::CFG_RECT_MAX_X: r_max_x <= i_cfg_data;
                trbb_pkg::CFG_RECT_MIN_Z: r_min_z <= i_cfg_data;
                trbb_pkg::CFG_RECT_MAX_Z: r_max_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    trbb_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .i_min_x (r_min_x),
        .i_max_x (r_max_x),
        .i_min_z (r_min_z),
        .i_max_z (r_max_z),
        .o_valid (w_x_vld),
        .o_degen (w_x_degen),
        .o_num   (w_num),
        .o_den   (w_den)
    );

    // twelve divider lanes, one per corner and component
    for (genvar k = 0; k < NK; k++) begin : g_corner
        for (genvar c = 0; c < NC; c++) begin : g_comp
            trbb_div u_div (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_valid (w_x_vld),
                .i_num   (w_num[k][c]),
                .i_den   (w_den[k]),
                .o_valid (w_d_vld[k][c]),
                .o_quot  (w_quot[k][c])
            );
        end
    end

    // zero-w flag rides alongside the divider lanes
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dg[0] <= w_x_degen;
            for (int s = 1; s < trbb_pkg::DIV_LAT; s++) begin
                r_dg[s] <= r_dg[s-1];
            end
        end
    end

    assign w_ctl = '{valid: w_d_vld[0][0], degen: r_dg[trbb_pkg::DIV_LAT-1]};

    trbb_minmax u_minmax (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_ctl),
        .i_q     (w_quot),
        .o_valid (o_out_valid),
        .o_data  (o_out_data)
    );

endmodule

/* design/trbb_checker.sv */
// Port-level checker for the transformed rectangle bounding box unit
`include "assert_macros.svh"

module trbb_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input trbb_pkg::t_out o_out_data
);

    logic w_box_zero;
    logic w_box_ordered;

    // all six box fields cleared
    assign w_box_zero = (o_out_data.box_min_x == 32'sd0) && (o_out_data.box_max_x == 32'sd0) &&
                        (o_out_data.box_min_y == 32'sd0) && (o_out_data.box_max_y == 32'sd0) &&
                        (o_out_data.box_min_z == 32'sd0) && (o_out_data.box_max_z == 32'sd0);

    // minimum never above maximum on any axis
    assign w_box_ordered = (o_out_data.box_min_x <= o_out_data.box_max_x) &&
                           (o_out_data.box_min_y <= o_out_data.box_max_y) &&
                           (o_out_data.box_min_z <= o_out_data.box_max_z);

    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled output word changed")
    `CHK_IMPLY(a_in_free, i_clk, i_rst_n, !o_out_valid, !o_in_stall, "input stalled with empty output")
    `CHK_IMPLY(a_degen_zero, i_clk, i_rst_n, o_out_valid && o_out_data.degenerate, w_box_zero, "degenerate word has non-zero box")
    `CHK_IMPLY(a_box_order, i_clk, i_rst_n, o_out_valid && !o_out_data.degenerate, w_box_ordered, "box minimum above maximum")

endmodule

bind transformed_rect_bounding_box_unit trbb_checker u_trbb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
